FILE: sv/rect_merge_adjacent_top_defines.svh
// Assertion helpers shared by the rect merge blocks.
// They expect clk and arst_n to be visible in the module that uses them.
`ifndef RECT_MERGE_ADJACENT_TOP_DEFINES_SVH
`define RECT_MERGE_ADJACENT_TOP_DEFINES_SVH

// Same-cycle implication.
`define RMA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RMA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/rma_pkg.sv
package rma_pkg;

	// Coordinate widths
	localparam int COORD_BITS = 15;
	localparam int OUT_BITS   = COORD_BITS + 1;

	// Pieces per pair and their counter widths
	localparam int MAX_PIECES     = 3;
	localparam int PIECE_IDX_BITS = $clog2(MAX_PIECES);
	localparam int PCNT_BITS      = $clog2(MAX_PIECES + 1);

	// Descriptor queue between front and back
	localparam int QDEPTH     = 2;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [OUT_BITS-1:0]   ocoord_t;

	// One input pair as captured by the front
	typedef struct packed {
		coord_t first_x;
		coord_t first_y;
		coord_t first_w;
		coord_t first_h;
		coord_t second_x;
		coord_t second_y;
		coord_t second_w;
		coord_t second_h;
	} pair_t;

	// One replacement rectangle
	typedef struct packed {
		ocoord_t x;
		ocoord_t y;
		ocoord_t w;
		ocoord_t h;
	} rect_t;

	// Work for the back: up to three pieces, emitted in order 0..cnt-1
	typedef struct packed {
		logic                 merged;
		logic [PCNT_BITS-1:0] cnt;
		rect_t [MAX_PIECES-1:0] pc;
	} desc_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: sv/rma_if.sv
// Pair channel: two rectangles per beat
interface rma_pair_if;
	logic valid;
	logic ready;
	rma_pkg::coord_t first_x;
	rma_pkg::coord_t first_y;
	rma_pkg::coord_t first_w;
	rma_pkg::coord_t first_h;
	rma_pkg::coord_t second_x;
	rma_pkg::coord_t second_y;
	rma_pkg::coord_t second_w;
	rma_pkg::coord_t second_h;

	modport source (
		output valid, first_x, first_y, first_w, first_h,
		output second_x, second_y, second_w, second_h,
		input  ready
	);
	modport sink (
		input  valid, first_x, first_y, first_w, first_h,
		input  second_x, second_y, second_w, second_h,
		output ready
	);
endinterface

// Result channel: one replacement rectangle per beat
interface rma_rect_if;
	logic valid;
	logic ready;
	rma_pkg::ocoord_t out_x;
	rma_pkg::ocoord_t out_y;
	rma_pkg::ocoord_t out_w;
	rma_pkg::ocoord_t out_h;
	logic merged;
	logic last_piece;

	modport source (
		output valid, out_x, out_y, out_w, out_h, merged, last_piece,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_w, out_h, merged, last_piece,
		output ready
	);
endinterface

FILE: sv/rma_front.sv
// Front: registers the pair, classifies it and builds the piece list.
module rma_front (
	input  logic              clk,
	input  logic              arst_n,
	rma_pair_if.sink          pair,
	input  rma_pkg::q_stat_t  qstat,
	output logic              push,
	output rma_pkg::desc_t    push_desc
);

	logic            valid_s1_q;
	rma_pkg::pair_t  pair_s1_q;

	rma_pkg::ocoord_t ax, ay, aw, ah, bx, by, bw, bh;
	rma_pkg::ocoord_t abot, bbot, a_right, b_right;

	function automatic rma_pkg::rect_t mk(input rma_pkg::ocoord_t x, input rma_pkg::ocoord_t y,
		input rma_pkg::ocoord_t w, input rma_pkg::ocoord_t h);
		rma_pkg::rect_t r;
		r.x = x;
		r.y = y;
		r.w = w;
		r.h = h;
		return r;
	endfunction

	// Stage 1 holds a pair until the queue takes its descriptor
	always_comb begin
		push       = valid_s1_q && !qstat.full;
		pair.ready = !valid_s1_q || !qstat.full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (pair.ready) begin
			valid_s1_q <= pair.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pair.valid && pair.ready) begin
			pair_s1_q.first_x  <= pair.first_x;
			pair_s1_q.first_y  <= pair.first_y;
			pair_s1_q.first_w  <= pair.first_w;
			pair_s1_q.first_h  <= pair.first_h;
			pair_s1_q.second_x <= pair.second_x;
			pair_s1_q.second_y <= pair.second_y;
			pair_s1_q.second_w <= pair.second_w;
			pair_s1_q.second_h <= pair.second_h;
		end
	end

	// Widen to output precision; all sums below then fit without carry-out
	always_comb begin
		ax      = rma_pkg::OUT_BITS'(pair_s1_q.first_x);
		ay      = rma_pkg::OUT_BITS'(pair_s1_q.first_y);
		aw      = rma_pkg::OUT_BITS'(pair_s1_q.first_w);
		ah      = rma_pkg::OUT_BITS'(pair_s1_q.first_h);
		bx      = rma_pkg::OUT_BITS'(pair_s1_q.second_x);
		by      = rma_pkg::OUT_BITS'(pair_s1_q.second_y);
		bw      = rma_pkg::OUT_BITS'(pair_s1_q.second_w);
		bh      = rma_pkg::OUT_BITS'(pair_s1_q.second_h);
		abot    = ay + ah;
		bbot    = by + bh;
		a_right = ax + aw;
		b_right = bx + bw;
	end

	// Classification and piece list
	always_comb begin
		push_desc        = '0;
		push_desc.merged = 1'b1;
		push_desc.cnt    = rma_pkg::PCNT_BITS'(1);
		if (ay > by || (ay == by && ax > bx)) begin
			push_desc.merged = 1'b0;
		end else if (ax == bx && aw == bw && abot == by) begin
			// vertical stack of equal width
			push_desc.pc[0] = mk(ax, ay, aw, ah + bh);
		end else if (a_right == bx && abot > by) begin
			// b to the right of a
			if (ay < by) begin
				push_desc.pc[0] = mk(ax, ay, aw, by - ay);
				if (abot < bbot) begin
					push_desc.pc[1] = mk(ax, by, aw + bw, abot - by);
					push_desc.pc[2] = mk(bx, abot, bw, bbot - abot);
					push_desc.cnt   = rma_pkg::PCNT_BITS'(3);
				end else if (abot == bbot) begin
					push_desc.pc[1] = mk(ax, by, aw + bw, bh);
					push_desc.cnt   = rma_pkg::PCNT_BITS'(2);
				end else begin
					push_desc.pc[1] = mk(ax, by, aw + bw, bh);
					push_desc.pc[2] = mk(ax, bbot, aw, abot - bbot);
					push_desc.cnt   = rma_pkg::PCNT_BITS'(3);
				end
			end else begin
				if (abot < bbot) begin
					push_desc.pc[0] = mk(ax, ay, aw + bw, ah);
					push_desc.pc[1] = mk(bx, abot, bw, bbot - abot);
					push_desc.cnt   = rma_pkg::PCNT_BITS'(2);
				end else if (abot == bbot) begin
					push_desc.pc[0] = mk(ax, ay, aw + bw, ah);
				end else begin
					push_desc.pc[0] = mk(ax, ay, aw + bw, bh);
					push_desc.pc[1] = mk(ax, bbot, aw, abot - bbot);
					push_desc.cnt   = rma_pkg::PCNT_BITS'(2);
				end
			end
		end else if (a_right == bx) begin
			push_desc.merged = 1'b0;
		end else if (ax == b_right && abot > by) begin
			// b to the left of a; top rest may have zero height
			push_desc.pc[0] = mk(ax, ay, aw, by - ay);
			if (bbot < abot) begin
				push_desc.pc[1] = mk(bx, by, bw + aw, bh);
				push_desc.pc[2] = mk(ax, bbot, aw, abot - bbot);
				push_desc.cnt   = rma_pkg::PCNT_BITS'(3);
			end else if (bbot == abot) begin
				push_desc.pc[1] = mk(bx, by, bw + aw, bh);
				push_desc.cnt   = rma_pkg::PCNT_BITS'(2);
			end else begin
				push_desc.pc[1] = mk(bx, by, bw + aw, abot - by);
				push_desc.pc[2] = mk(bx, abot, bw, bbot - abot);
				push_desc.cnt   = rma_pkg::PCNT_BITS'(3);
			end
		end else begin
			push_desc.merged = 1'b0;
		end
	end

endmodule

FILE: sv/rma_fifo.sv
`include "rect_merge_adjacent_top_defines.svh"

// Short descriptor queue between front and back.
module rma_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rma_pkg::desc_t    push_desc,
	input  logic              pop,
	output rma_pkg::desc_t    head,
	output rma_pkg::q_stat_t  qstat
);

	rma_pkg::desc_t                    mem_q [rma_pkg::QDEPTH];
	logic [rma_pkg::QPTR_BITS-1:0]     wr_ptr_q;
	logic [rma_pkg::QPTR_BITS-1:0]     rd_ptr_q;
	logic [rma_pkg::QCNT_BITS-1:0]     count_q;

	always_comb begin
		qstat.full  = (count_q == rma_pkg::QCNT_BITS'(rma_pkg::QDEPTH));
		qstat.empty = (count_q == '0);
		head        = mem_q[rd_ptr_q];
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + rma_pkg::QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + rma_pkg::QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + rma_pkg::QCNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - rma_pkg::QCNT_BITS'(1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	`RMA_ASSERT_NOW(a_no_push_full, push, !qstat.full, "queue written while full")
	`RMA_ASSERT_NOW(a_no_pop_empty, pop, !qstat.empty, "queue read while empty")
	`RMA_ASSERT_NEXT(a_fill_up, push && !pop, count_q == $past(count_q) + rma_pkg::QCNT_BITS'(1), "fill level lost a beat")

endmodule

FILE: sv/rma_back.sv
`include "rect_merge_adjacent_top_defines.svh"

// Back: walks the head descriptor one piece per cycle, unless stalled, into the output register.
module rma_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rma_pkg::desc_t    head,
	input  rma_pkg::q_stat_t  qstat,
	output logic              pop,
	rma_rect_if.source        rect
);

	logic [rma_pkg::PIECE_IDX_BITS-1:0] idx_q;
	logic                               valid_q;
	rma_pkg::rect_t                     rect_q;
	logic                               merged_q;
	logic                               last_q;

	logic load;
	logic take;
	logic is_last;

	// Output register refills when empty or being drained
	always_comb begin
		load    = !valid_q || rect.ready;
		take    = load && !qstat.empty;
		is_last = (rma_pkg::PCNT_BITS'(idx_q) + rma_pkg::PCNT_BITS'(1)) == head.cnt;
		pop     = take && is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= !qstat.empty;
			end
			if (take) begin
				idx_q <= is_last ? '0 : idx_q + rma_pkg::PIECE_IDX_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rect_q   <= head.pc[idx_q];
			merged_q <= head.merged;
			last_q   <= is_last;
		end
	end

	assign rect.valid      = valid_q;
	assign rect.out_x      = rect_q.x;
	assign rect.out_y      = rect_q.y;
	assign rect.out_w      = rect_q.w;
	assign rect.out_h      = rect_q.h;
	assign rect.merged     = merged_q;
	assign rect.last_piece = last_q;

	`RMA_ASSERT_NOW(a_idx_in_range, !qstat.empty, rma_pkg::PCNT_BITS'(idx_q) < head.cnt, "piece index past count")
	`RMA_ASSERT_NOW(a_unmerged_last, valid_q && !merged_q, last_q, "unmerged beat not last")
	`RMA_ASSERT_NEXT(a_idx_wrap, pop, idx_q == '0, "piece index not rewound after pop")

endmodule

FILE: sv/rect_merge_adjacent_top.sv
// Rectangle pair merger.
// pair channel (sink): one beat carries rectangles a (first_*) and b (second_*),
// a at or before b in row-major order. rect channel (source): for each pair
// one to three beats, the replacement rectangles in order; last_piece marks
// the final beat of a pair. A pair that does not merge gives a single beat
// with zero coordinates, merged low and last_piece high.
// A pair passes the input stage, the descriptor queue and the output register
// in that order. Pieces leave at one per cycle while the receiver is ready,
// from a single output register, one beat per piece (1 to 3) for each pair;
// pairs are accepted back to back while the descriptor queue has room.
// Reset (arst_n low) empties the input stage, the queue and the output
// register; nothing is pending afterwards.
// When the receiver holds ready low the output beat is held, the back stops
// draining the queue, and once the queue is full and the input stage holds a
// pair the front deasserts ready on the pair channel.
module rect_merge_adjacent_top (
	input  logic        clk,
	input  logic        arst_n,
	rma_pair_if.sink    pair,
	rma_rect_if.source  rect
);

	logic              push;
	logic              pop;
	rma_pkg::desc_t    push_desc;
	rma_pkg::desc_t    head;
	rma_pkg::q_stat_t  qstat;

	rma_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair      (pair),
		.qstat     (qstat),
		.push      (push),
		.push_desc (push_desc)
	);

	rma_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	rma_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.rect   (rect)
	);

endmodule

FILE: tb/rect_merge_adjacent_top_tb.sv
module rect_merge_adjacent_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef rma_pkg::coord_t  coord_t;
	typedef rma_pkg::ocoord_t ocoord_t;
	typedef rma_pkg::pair_t   pair_t;

	localparam int QUIET_LIMIT = 2000;
	localparam int COORD_MAX   = (1 << rma_pkg::COORD_BITS) - 1;

	// One replacement rectangle as the block should emit it
	typedef struct {
		ocoord_t x;
		ocoord_t y;
		ocoord_t w;
		ocoord_t h;
		logic    merged;
		logic    last_piece;
	} piece_t;

	logic clk = 1'b0;
	logic arst_n;

	rma_pair_if pair_ch ();
	rma_rect_if rect_ch ();

	rect_merge_adjacent_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_ch),
		.rect   (rect_ch)
	);

	piece_t pending_pieces[$];
	int     mismatch_cnt = 0;
	int     quiet_cycles = 0;
	bit     calm = 1'b0;

	always #4 clk = ~clk;

	// Build one merged piece, masked to the output width
	function automatic piece_t merged_piece(int x, int y, int w, int h);
		piece_t pc;
		pc.x = ocoord_t'(x);
		pc.y = ocoord_t'(y);
		pc.w = ocoord_t'(w);
		pc.h = ocoord_t'(h);
		pc.merged = 1'b1;
		pc.last_piece = 1'b0;
		return pc;
	endfunction

	// Work out the replacement rectangles for one accepted pair
	function automatic void predict_merge(input pair_t p);
		int ax, ay, aw, ah, bx, by, bw, bh, abot, bbot;
		piece_t got[$];
		piece_t none;
		ax = p.first_x;
		ay = p.first_y;
		aw = p.first_w;
		ah = p.first_h;
		bx = p.second_x;
		by = p.second_y;
		bw = p.second_w;
		bh = p.second_h;
		abot = ay + ah;
		bbot = by + bh;
		if (ay > by || (ay == by && ax > bx)) begin
			// out of row-major order: nothing merges
		end else if (ax == bx && aw == bw && abot == by) begin
			got = {got, merged_piece(ax, ay, aw, ah + bh)};
		end else if (ax + aw == bx) begin
			// b on the right of a
			if (abot > by) begin
				if (ay < by) begin
					got = {got, merged_piece(ax, ay, aw, by - ay)};
					if (abot < bbot) begin
						got = {got, merged_piece(ax, by, aw + bw, abot - by)};
						got = {got, merged_piece(bx, abot, bw, bbot - abot)};
					end else if (abot == bbot) begin
						got = {got, merged_piece(ax, by, aw + bw, bh)};
					end else begin
						got = {got, merged_piece(ax, by, aw + bw, bh)};
						got = {got, merged_piece(ax, bbot, aw, abot - bbot)};
					end
				end else begin
					// equal tops: rest below the shorter one sits under the taller one
					if (abot < bbot) begin
						got = {got, merged_piece(ax, ay, aw + bw, ah)};
						got = {got, merged_piece(bx, abot, bw, bbot - abot)};
					end else if (abot == bbot) begin
						got = {got, merged_piece(ax, ay, aw + bw, ah)};
					end else begin
						got = {got, merged_piece(ax, ay, aw + bw, bh)};
						got = {got, merged_piece(ax, bbot, aw, abot - bbot)};
					end
				end
			end
		end else if (ax == bx + bw) begin
			// b on the left of a
			if (abot > by) begin
				got = {got, merged_piece(ax, ay, aw, by - ay)};
				if (bbot < abot) begin
					got = {got, merged_piece(bx, by, bw + aw, bh)};
					got = {got, merged_piece(ax, bbot, aw, abot - bbot)};
				end else if (bbot == abot) begin
					got = {got, merged_piece(bx, by, bw + aw, bh)};
				end else begin
					// strip height is the overlap only
					got = {got, merged_piece(bx, by, bw + aw, abot - by)};
					got = {got, merged_piece(bx, abot, bw, bbot - abot)};
				end
			end
		end

		if (got.size() == 0) begin
			none = '{'0, '0, '0, '0, 1'b0, 1'b1};
			pending_pieces = {pending_pieces, none};
		end else begin
			got[got.size() - 1].last_piece = 1'b1;
			pending_pieces = {pending_pieces, got};
		end
	endfunction

	// Random size or position in [0, room], small values half the time
	function automatic int pick_span(int room);
		if ($urandom_range(1) == 0)
			return $urandom_range((room < 16) ? room : 16);
		return $urandom_range(room);
	endfunction

	// Mostly touching pairs with random content, some noise and swapped pairs
	function automatic pair_t random_pair();
		int ax, ay, aw, ah, bx, by, bw, bh, kind, t;
		pair_t p;
		kind = $urandom_range(9);
		if (kind < 2) begin
			// vertical stack
			ax = $urandom_range(COORD_MAX);
			aw = pick_span(COORD_MAX);
			ay = pick_span(COORD_MAX);
			ah = pick_span(COORD_MAX - ay);
			bx = ax;
			bw = aw;
			by = ay + ah;
			bh = pick_span(COORD_MAX);
		end else if (kind < 5 || kind == 9) begin
			// b on the right, rows overlapping or just touching
			ax = pick_span(COORD_MAX);
			aw = pick_span(COORD_MAX - ax);
			bx = ax + aw;
			bw = pick_span(COORD_MAX);
			ay = pick_span(COORD_MAX);
			ah = pick_span(COORD_MAX);
			by = ay + pick_span((ah < COORD_MAX - ay) ? ah : COORD_MAX - ay);
			bh = pick_span(COORD_MAX);
			if (kind == 9) begin
				t = ax; ax = bx; bx = t;
				t = ay; ay = by; by = t;
				t = aw; aw = bw; bw = t;
				t = ah; ah = bh; bh = t;
			end
		end else if (kind < 7) begin
			// b on the left
			bx = pick_span(COORD_MAX);
			bw = pick_span(COORD_MAX - bx);
			ax = bx + bw;
			aw = pick_span(COORD_MAX);
			ay = pick_span(COORD_MAX);
			ah = pick_span(COORD_MAX);
			by = ay + pick_span((ah < COORD_MAX - ay) ? ah : COORD_MAX - ay);
			bh = pick_span(COORD_MAX);
		end else if (kind == 7) begin
			ax = $urandom_range(COORD_MAX);
			ay = $urandom_range(COORD_MAX);
			aw = $urandom_range(COORD_MAX);
			ah = $urandom_range(COORD_MAX);
			bx = $urandom_range(COORD_MAX);
			by = $urandom_range(COORD_MAX);
			bw = $urandom_range(COORD_MAX);
			bh = $urandom_range(COORD_MAX);
		end else begin
			// tiny values make chance coincidences likely
			ax = $urandom_range(15);
			ay = $urandom_range(15);
			aw = $urandom_range(15);
			ah = $urandom_range(15);
			bx = $urandom_range(15);
			by = $urandom_range(15);
			bw = $urandom_range(15);
			bh = $urandom_range(15);
		end
		p.first_x  = coord_t'(ax);
		p.first_y  = coord_t'(ay);
		p.first_w  = coord_t'(aw);
		p.first_h  = coord_t'(ah);
		p.second_x = coord_t'(bx);
		p.second_y = coord_t'(by);
		p.second_w = coord_t'(bw);
		p.second_h = coord_t'(bh);
		return p;
	endfunction

	// Send one pair; called at a rising edge, returns at the accepting edge
	task automatic send_pair(input pair_t p);
		while (!calm && $urandom_range(99) < 9) begin
			pair_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pair_ch.valid    <= 1'b1;
		pair_ch.first_x  <= p.first_x;
		pair_ch.first_y  <= p.first_y;
		pair_ch.first_w  <= p.first_w;
		pair_ch.first_h  <= p.first_h;
		pair_ch.second_x <= p.second_x;
		pair_ch.second_y <= p.second_y;
		pair_ch.second_w <= p.second_w;
		pair_ch.second_h <= p.second_h;
		@(posedge clk);
		while (!pair_ch.ready)
			@(posedge clk);
		predict_merge(p);
	endtask

	// Compare one result beat with the oldest expected rectangle
	task automatic check_piece();
		piece_t want;
		if (pending_pieces.size() == 0) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("%0t: unexpected rect beat x=%0d y=%0d w=%0d h=%0d m=%b l=%b",
					$time, rect_ch.out_x, rect_ch.out_y, rect_ch.out_w, rect_ch.out_h,
					rect_ch.merged, rect_ch.last_piece);
		end else begin
			want = pending_pieces.pop_front();
			if (rect_ch.out_x !== want.x || rect_ch.out_y !== want.y ||
					rect_ch.out_w !== want.w || rect_ch.out_h !== want.h ||
					rect_ch.merged !== want.merged ||
					rect_ch.last_piece !== want.last_piece) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: rect mismatch exp x=%0d y=%0d w=%0d h=%0d m=%b l=%b",
						$time, want.x, want.y, want.w, want.h, want.merged,
						want.last_piece, "\n    got x=%0d y=%0d w=%0d h=%0d m=%b l=%b",
						rect_ch.out_x, rect_ch.out_y, rect_ch.out_w, rect_ch.out_h,
						rect_ch.merged, rect_ch.last_piece);
			end
		end
	endtask

	// Result side: check accepted beats, stall at random
	always @(posedge clk) begin
		if (arst_n && rect_ch.valid && rect_ch.ready)
			check_piece();
		rect_ch.ready <= calm || ($urandom_range(99) >= 9);
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (pair_ch.valid && pair_ch.ready) || (rect_ch.valid && rect_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** rect_merge_adjacent_top: FAILED **");
			$finish;
		end
	end

	// Stacks of equal width, extremes and zero sizes
	task automatic test_stack_merges();
		send_pair(pair_t'{15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0});
		send_pair(pair_t'{15'd10, 15'd20, 15'd30, 15'd5, 15'd10, 15'd25, 15'd30, 15'd7});
		send_pair(pair_t'{15'd0, 15'd0, 15'd32767, 15'd32767,
			15'd0, 15'd32767, 15'd32767, 15'd32767});
		// zero widths: the stack test wins over side by side
		send_pair(pair_t'{15'd5, 15'd5, 15'd0, 15'd3, 15'd5, 15'd8, 15'd0, 15'd4});
	endtask

	// Side by side, every height relation, both sides
	task automatic test_side_merges();
		send_pair(pair_t'{15'd0, 15'd0, 15'd10, 15'd10, 15'd10, 15'd4, 15'd6, 15'd20});
		send_pair(pair_t'{15'd0, 15'd0, 15'd10, 15'd10, 15'd10, 15'd4, 15'd6, 15'd6});
		send_pair(pair_t'{15'd0, 15'd0, 15'd10, 15'd20, 15'd10, 15'd4, 15'd6, 15'd6});
		// equal tops, rest below goes to b, then none, then to a
		send_pair(pair_t'{15'd0, 15'd5, 15'd10, 15'd10, 15'd10, 15'd5, 15'd6, 15'd20});
		send_pair(pair_t'{15'd0, 15'd5, 15'd10, 15'd10, 15'd10, 15'd5, 15'd6, 15'd10});
		send_pair(pair_t'{15'd0, 15'd5, 15'd10, 15'd20, 15'd10, 15'd5, 15'd6, 15'd10});
		// b on the left
		send_pair(pair_t'{15'd20, 15'd0, 15'd5, 15'd10, 15'd10, 15'd3, 15'd10, 15'd4});
		send_pair(pair_t'{15'd20, 15'd0, 15'd5, 15'd10, 15'd10, 15'd3, 15'd10, 15'd7});
		send_pair(pair_t'{15'd20, 15'd0, 15'd5, 15'd10, 15'd10, 15'd3, 15'd10, 15'd20});
		// wide sums beyond the input width
		send_pair(pair_t'{15'd16383, 15'd0, 15'd16384, 15'd32767,
			15'd32767, 15'd0, 15'd32767, 15'd32767});
		// zero-height pieces
		send_pair(pair_t'{15'd0, 15'd3, 15'd4, 15'd1, 15'd4, 15'd3, 15'd4, 15'd0});
		send_pair(pair_t'{15'd7, 15'd2, 15'd3, 15'd5, 15'd7, 15'd2, 15'd0, 15'd9});
	endtask

	// Pairs that give a single not-merged beat
	task automatic test_no_merge();
		send_pair(pair_t'{15'd32767, 15'd32767, 15'd32767, 15'd32767,
			15'd32767, 15'd32767, 15'd32767, 15'd32767});
		send_pair(pair_t'{15'd0, 15'd0, 15'd10, 15'd4, 15'd10, 15'd4, 15'd6, 15'd5});
		send_pair(pair_t'{15'd20, 15'd0, 15'd5, 15'd3, 15'd10, 15'd3, 15'd10, 15'd4});
		send_pair(pair_t'{15'd0, 15'd10, 15'd5, 15'd5, 15'd5, 15'd9, 15'd5, 15'd5});
		send_pair(pair_t'{15'd10, 15'd5, 15'd5, 15'd5, 15'd0, 15'd5, 15'd10, 15'd5});
		send_pair(pair_t'{15'd0, 15'd0, 15'd5, 15'd5, 15'd20, 15'd2, 15'd5, 15'd5});
		send_pair(pair_t'{15'd32767, 15'd32767, 15'd32767, 15'd32767,
			15'd0, 15'd32767, 15'd32767, 15'd32767});
	endtask

	// Random pairs, both sides at full rate
	task automatic test_random_calm();
		calm = 1'b1;
		repeat (60)
			send_pair(random_pair());
		calm = 1'b0;
	endtask

	// Random pairs with gaps and stalls on both sides
	task automatic test_random_busy();
		repeat (127)
			send_pair(random_pair());
	endtask

	initial begin
		arst_n           = 1'b0;
		pair_ch.valid    = 1'b0;
		pair_ch.first_x  = '0;
		pair_ch.first_y  = '0;
		pair_ch.first_w  = '0;
		pair_ch.first_h  = '0;
		pair_ch.second_x = '0;
		pair_ch.second_y = '0;
		pair_ch.second_w = '0;
		pair_ch.second_h = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stack_merges();
		test_side_merges();
		test_no_merge();
		test_random_calm();
		test_random_busy();

		// drain, then allow the output pipe to settle
		pair_ch.valid <= 1'b0;
		while (pending_pieces.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("** rect_merge_adjacent_top: PASSED **");
		else
			$display("** rect_merge_adjacent_top: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/rma_pkg.sv
sv/rma_if.sv
sv/rma_front.sv
sv/rma_fifo.sv
sv/rma_back.sv
sv/rect_merge_adjacent_top.sv
tb/rect_merge_adjacent_top_tb.sv
